>>> src/mshw_pkg.sv
// Shared types and constants for the multi-slot heartbeat watchdog.
// No dependencies; imported by every module of the block and by its checker.
package mshw_pkg;

    // Request kinds carried on req_type.
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_RESERVE = 2'd1;
    localparam logic [1:0] REQ_PATROL  = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    // Slot status codes.
    localparam logic [2:0] ST_FREE      = 3'd0;
    localparam logic [2:0] ST_CLAIMED   = 3'd1;
    localparam logic [2:0] ST_IDLE      = 3'd2;
    localparam logic [2:0] ST_BUSY      = 3'd3;
    localparam logic [2:0] ST_CLEAR     = 3'd4;
    localparam logic [2:0] ST_TERMINATE = 3'd5;

    localparam logic [15:0]        BASE_TTL_RESET = 16'd5;
    localparam logic signed [16:0] TTL_RESET      = 17'sd5;
    localparam logic signed [16:0] TTL_FLOOR      = -17'sd1;

    localparam int   APB_ADDR_W   = 3;
    localparam logic REG_BASE_TTL = 1'b0;

    typedef struct packed {
        logic [2:0]        status;
        logic [2:0]        prior;
        logic signed [16:0] ttl;
    } entry_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic advance;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       last;
        logic       free_hit;
        logic       out_free;
    } dp_stat_t;

endpackage

>>> src/mshw_datapath.sv
// Datapath of the watchdog: slot entry memory, per-slot valid and kill bits,
// slot evaluation and the response register. Depends on mshw_pkg.
module mshw_datapath #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mshw_pkg::dp_cmd_t   cmd,
    output mshw_pkg::dp_stat_t  stat,
    input  logic [1:0]          req_type,
    input  logic [3:0]          slot_index,
    input  logic [2:0]          new_status,
    input  logic [15:0]         base_ttl,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic                reserve_ok,
    output logic [3:0]          reserved_slot,
    output logic [2:0]          slot_state,
    output logic signed [16:0]  slot_ttl,
    output logic                all_terminated
);
    import mshw_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    entry_t entry_mem [SLOT_COUNT];
    entry_t rdata_reg;

    logic [1:0]            kind_reg;
    logic [2:0]            st_reg;
    logic                  rng_reg;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [SLOT_COUNT-1:0] vld_reg, vld_next;
    logic [SLOT_COUNT-1:0] kmask_reg, kmask_next;
    logic                  flag_reg, flag_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  ok_reg;
    logic [3:0]            slot_reg;
    logic [2:0]            state_reg;
    logic signed [16:0]    ttl_reg;
    logic                  term_reg;

    logic               in_range, scan_in, re, we;
    logic [IDX_W-1:0]   raddr;
    logic signed [16:0] base_ext, ttl_cur, ttl_dec, ttl_new;
    logic [2:0]         seen, prior, wr_st, p_st;
    logic               p_dec, p_kill, p_kill_now, kill_req, kill_now;
    entry_t             wdata;
    logic               res_ok;
    logic [3:0]         res_slot;
    logic [2:0]         res_state;
    logic signed [16:0] res_ttl;

    assign in_range = (int'(slot_index) < SLOT_COUNT);
    assign scan_in  = (req_type == REQ_RESERVE) || (req_type == REQ_PATROL);
    assign base_ext = $signed({1'b0, base_ttl});
    assign raddr    = cmd.load ? (scan_in ? '0 : IDX_W'(slot_index)) : ptr_reg + IDX_W'(1);
    assign re       = (cmd.load && (scan_in || in_range)) || cmd.advance;

    // An entry never written since reset reads as its reset contents; a kill
    // bit overrides the stored status until the entry is written again.
    always_comb
    begin
        seen    = kmask_reg[ptr_reg] ? ST_TERMINATE :
                  (vld_reg[ptr_reg] ? rdata_reg.status : ST_FREE);
        prior   = vld_reg[ptr_reg] ? rdata_reg.prior : ST_FREE;
        ttl_cur = vld_reg[ptr_reg] ? rdata_reg.ttl : TTL_RESET;
        ttl_dec = (ttl_cur > TTL_FLOOR) ? ttl_cur - 17'sd1 : ttl_cur;

        p_dec      = (seen == ST_CLAIMED) || (seen == ST_CLEAR) ||
                     ((seen == ST_BUSY) && (prior == ST_BUSY));
        p_kill     = (ttl_cur <= 17'sd0) || (seen == ST_TERMINATE) ||
                     (p_dec && (ttl_dec < 17'sd0));
        p_kill_now = p_kill && !flag_reg;
        // An idle slot still turns clear even if this check terminated all.
        p_st       = (seen == ST_IDLE) ? ST_CLEAR : (p_kill_now ? ST_TERMINATE : seen);
        ttl_new    = (seen == ST_IDLE) ? base_ext : (p_dec ? ttl_dec : ttl_cur);
        wr_st      = (st_reg <= ST_TERMINATE) ? st_reg : seen;

        we        = 1'b0;
        kill_req  = 1'b0;
        wdata     = '{status: wr_st, prior: prior, ttl: ttl_cur};
        res_ok    = 1'b0;
        res_slot  = 4'd0;
        res_state = 3'd0;
        res_ttl   = 17'sd0;
        unique case (kind_reg)
            REQ_WRITE, REQ_READ:
            begin
                we = (kind_reg == REQ_WRITE) && rng_reg;
                if (rng_reg)
                begin
                    res_state = (kind_reg == REQ_WRITE) ? wr_st : seen;
                    res_ttl   = ttl_cur;
                end
            end
            REQ_RESERVE:
            begin
                we       = (seen == ST_FREE);
                kill_req = (seen != ST_FREE) && (ptr_reg == LAST_IDX);
                wdata    = '{status: ST_CLAIMED, prior: ST_FREE, ttl: base_ext};
                if (seen == ST_FREE)
                begin
                    res_ok    = 1'b1;
                    res_slot  = 4'(ptr_reg);
                    res_state = ST_CLAIMED;
                    res_ttl   = base_ext;
                end
            end
            REQ_PATROL:
            begin
                we       = 1'b1;
                kill_req = p_kill;
                wdata    = '{status: p_st, prior: p_st, ttl: ttl_new};
            end
        endcase
        kill_now = kill_req && !flag_reg;
    end

    always_comb
    begin
        flag_next  = flag_reg;
        kmask_next = kmask_reg;
        vld_next   = vld_reg;
        if (cmd.exec && kill_now)
        begin
            flag_next  = 1'b1;
            kmask_next = '1;
        end
        if (cmd.exec && we)
        begin
            kmask_next[ptr_reg] = 1'b0;
            vld_next[ptr_reg]   = 1'b1;
        end
        ptr_next = ptr_reg;
        if (cmd.load || cmd.advance)
        begin
            ptr_next = raddr;
        end
        rsp_valid_next = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= 1'b0;
            kmask_reg     <= '0;
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            kind_reg      <= REQ_READ;
        end
        else
        begin
            flag_reg      <= flag_next;
            kmask_reg     <= kmask_next;
            vld_reg       <= vld_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.load)
            begin
                kind_reg <= req_type;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            st_reg   <= new_status;
            rng_reg  <= in_range;
        end
        if (cmd.finish)
        begin
            ok_reg    <= res_ok;
            slot_reg  <= res_slot;
            state_reg <= res_state;
            ttl_reg   <= res_ttl;
            term_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && we)
        begin
            entry_mem[ptr_reg] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= entry_mem[raddr];
        end
    end

    assign stat = '{kind: kind_reg, last: (ptr_reg == LAST_IDX),
                    free_hit: (seen == ST_FREE), out_free: (!rsp_valid_reg || rsp_ready)};

    assign rsp_valid      = rsp_valid_reg;
    assign reserve_ok     = ok_reg;
    assign reserved_slot  = slot_reg;
    assign slot_state     = state_reg;
    assign slot_ttl       = ttl_reg;
    assign all_terminated = term_reg;

endmodule

>>> src/mshw_ctrl.sv
// Controller of the watchdog: sequences one request over the slot memory.
// Depends on mshw_pkg for the command and status structs and request kinds.
module mshw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mshw_pkg::dp_stat_t stat,
    output mshw_pkg::dp_cmd_t  cmd
);
    import mshw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   done;

    // The last step of a request also loads the response, so it waits for room.
    always_comb
    begin
        unique case (stat.kind)
            REQ_WRITE, REQ_READ: done = 1'b1;
            REQ_RESERVE:         done = stat.free_hit || stat.last;
            REQ_PATROL:          done = stat.last;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!done)
                begin
                    cmd.exec    = 1'b1;
                    cmd.advance = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/multi_slot_heartbeat_watchdog.sv
// Top level of the multi-slot heartbeat watchdog: configuration register and
// the controller and datapath. Depends on mshw_pkg, mshw_ctrl, mshw_datapath.
//
// Requests arrive on req_valid/req_ready with req_type, slot_index and
// new_status; each request gives exactly one response on rsp_valid/rsp_ready.
// base_ttl is written through the APB port at byte address 0.
// Work per request, from the accepting edge to the edge that raises rsp_valid:
//   status write or read: only the addressed slot; reserve: slots from 0 up
//   to the first FREE one, or every slot on failure; patrol tick: every slot.
// The slot entries sit in one memory with a registered read port, walked one
// slot per cycle, and one request is worked on at a time.
// Reset is immediate: per-slot valid bits make every slot read FREE with a
// counter of 5 until first written, so no clearing pass is needed.
// If the receiver stalls, the response holds in its output register and the
// next request runs up to its last step, then waits for the register to free.
module multi_slot_heartbeat_watchdog #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mshw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [1:0]                    req_type,
    input  logic [3:0]                    slot_index,
    input  logic [2:0]                    new_status,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          reserve_ok,
    output logic [3:0]                    reserved_slot,
    output logic [2:0]                    slot_state,
    output logic signed [16:0]            slot_ttl,
    output logic                          all_terminated
);
    import mshw_pkg::*;

    logic [15:0] base_ttl_reg, base_ttl_next;
    logic        cfg_we;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        base_ttl_next = base_ttl_reg;
        if (cfg_we && (paddr[2] == REG_BASE_TTL))
        begin
            base_ttl_next = pwdata[15:0];
        end
        prdata = (paddr[2] == REG_BASE_TTL) ? {16'd0, base_ttl_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_ttl_reg <= BASE_TTL_RESET;
        end
        else
        begin
            base_ttl_reg <= base_ttl_next;
        end
    end

    mshw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mshw_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .slot_index     (slot_index),
        .new_status     (new_status),
        .base_ttl       (base_ttl_reg),
        .rsp_ready      (rsp_ready),
        .rsp_valid      (rsp_valid),
        .reserve_ok     (reserve_ok),
        .reserved_slot  (reserved_slot),
        .slot_state     (slot_state),
        .slot_ttl       (slot_ttl),
        .all_terminated (all_terminated)
    );

endmodule

>>> src/mshw_checker.sv
// Port-level checker for the multi-slot heartbeat watchdog, bound to the top.
// Depends on mshw_pkg and multi_slot_heartbeat_watchdog.
module mshw_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               reserve_ok,
    input logic [3:0]         reserved_slot,
    input logic [2:0]         slot_state,
    input logic signed [16:0] slot_ttl,
    input logic               all_terminated
);
    import mshw_pkg::*;

    logic seen_term_reg, seen_term_next;

    assign seen_term_next = seen_term_reg || (rsp_valid && all_terminated);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_term_reg <= 1'b0;
        end
        else
        begin
            seen_term_reg <= seen_term_next;
        end
    end

    // A stalled response holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
        $stable({reserve_ok, reserved_slot, slot_state, slot_ttl, all_terminated}))
        else $error("response changed while stalled");

    // Termination is permanent until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && seen_term_reg |-> all_terminated)
        else $error("terminated flag dropped");

    // A successful reserve reports a claimed slot; otherwise no slot number.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (reserve_ok ? ((slot_state == ST_CLAIMED) && !slot_ttl[16])
                                  : (reserved_slot == 4'd0)))
        else $error("reserve result fields inconsistent");

    // The block cannot accept a request in the cycle after it accepts one.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // Counters saturate at minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (slot_ttl >= TTL_FLOOR))
        else $error("counter below floor");

endmodule

bind multi_slot_heartbeat_watchdog mshw_checker u_checker (.*);
